>>> design/polyphase_resample_mac_assert.svh
// assertion macros shared by the resampler modules
`ifndef POLYPHASE_RESAMPLE_MAC_ASSERT_SVH
`define POLYPHASE_RESAMPLE_MAC_ASSERT_SVH

// condition holds in the same cycle
`define PRM_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("resampler check failed");

// condition holds in the next cycle
`define PRM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("resampler check failed");

`endif

>>> design/prm_pkg.sv
`default_nettype none

package prm_pkg;

    localparam int MAX_TAPS      = 16;
    localparam int MAX_POSITIONS = 1024;
    localparam int STORE_DEPTH   = MAX_TAPS * MAX_POSITIONS;
    localparam int ADDR_W        = $clog2(STORE_DEPTH);

    localparam int COEF_W   = 16;
    localparam int SAMPLE_W = 16;
    localparam int POS_W    = 10;
    localparam int TAP_W    = 4;
    localparam int CFG_W    = 5;
    localparam int PIXEL_W  = 16;
    localparam int SMP_W    = SAMPLE_W + 1;
    localparam int PROD_W   = SMP_W + COEF_W;
    localparam int ACC_W    = 48;
    localparam int SUM_W    = ACC_W + 1;

    localparam int SHIFT_HI = 14;
    localparam int SHIFT_LO = 13;
    localparam int BIAS     = 32768;

    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    // register indexes
    localparam logic CFG_SAMPLE_BITS = 1'b0;
    localparam logic CFG_TAPS        = 1'b1;

    // item kinds
    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_TAP  = 1'b1;

    typedef struct packed {
        logic                shift14;
        logic                bias_on;
        logic [PIXEL_W-1:0]  clamp_max;
    } t_mode;

    typedef struct packed {
        logic                    valid;
        logic signed [ACC_W-1:0] acc;
    } t_fin;

    function automatic t_mode mode_of(input logic [CFG_W-1:0] bits);
        t_mode            m;
        logic [CFG_W-1:0] b;
        b           = (bits > CFG_W'(16)) ? CFG_W'(16) : bits;
        m.shift14   = (bits == CFG_W'(8));
        m.bias_on   = (bits == CFG_W'(16));
        m.clamp_max = PIXEL_W'((17'(1) << b) - 17'(1));
        return m;
    endfunction

endpackage

`default_nettype wire

>>> design/polyphase_resample_mac.sv
// throughput: one request (coefficient load or tap) per cycle while o_stall is low
// path: after its last tap is accepted, the pixel is registered in turn through
// coefficient store read, multiply, accumulate, and clamp into the output register
// the input stalls only while a finished pixel waits behind a stalled output
// reset (synchronous, active low): no pixel open, sample_bits 8, taps_per_position 16;
// the coefficient store is not cleared and must be loaded before use
`default_nettype none
`include "polyphase_resample_mac_assert.svh"

module polyphase_resample_mac (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic                               i_cfg_index,
    input  wire logic [prm_pkg::CFG_W-1:0]          i_cfg_data,
    input  wire logic                               i_valid,
    output logic                                    o_stall,
    input  wire logic                               i_mode,
    input  wire logic [prm_pkg::ADDR_W-1:0]         i_coef_index,
    input  wire logic signed [prm_pkg::COEF_W-1:0]  i_coef_value,
    input  wire logic [prm_pkg::SAMPLE_W-1:0]       i_sample,
    input  wire logic [prm_pkg::POS_W-1:0]          i_position,
    input  wire logic [prm_pkg::TAP_W-1:0]          i_tap,
    input  wire logic                               i_last_tap,
    output logic                                    o_valid,
    input  wire logic                               i_stall,
    output logic [prm_pkg::PIXEL_W-1:0]             o_pixel
);

    import prm_pkg::*;

    t_mode              r_mode;
    logic [CFG_W-1:0]   r_taps;
    logic               r_s1_valid;
    logic [SAMPLE_W-1:0] r_s1_sample;
    logic               r_s1_last;

    logic               en;
    logic               accept;
    logic               load_we;
    logic [ADDR_W-1:0]  tap_addr;
    logic [COEF_W-1:0]  coef;
    t_fin               fin;

    // the pipe freezes only when a pixel is ready and the output slot is full and stalled
    assign en      = !(fin.valid && o_valid && i_stall);
    assign o_stall = !en;
    assign accept  = i_valid && en;
    assign load_we = accept && (i_mode == MODE_LOAD);

    assign tap_addr = ADDR_W'(32'(i_position) * 32'(r_taps) + 32'(i_tap));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= mode_of(CFG_W'(8));
            r_taps <= CFG_W'(16);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SAMPLE_BITS: r_mode <= mode_of(i_cfg_data);
                CFG_TAPS:        r_taps <= i_cfg_data;
                default:         r_taps <= r_taps;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (en) begin
            r_s1_valid <= accept && (i_mode == MODE_TAP);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_sample <= i_sample;
            r_s1_last   <= i_last_tap;
        end
    end

    prm_ram #(
        .WIDTH (COEF_W),
        .DEPTH (STORE_DEPTH)
    ) u_coef_ram (
        .i_clk   (i_clk),
        .i_we    (load_we),
        .i_waddr (i_coef_index),
        .i_wdata (i_coef_value),
        .i_re    (en),
        .i_raddr (tap_addr),
        .o_rdata (coef)
    );

    prm_mac u_mac (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (en),
        .i_mode      (r_mode),
        .i_s1_valid  (r_s1_valid),
        .i_s1_sample (r_s1_sample),
        .i_s1_last   (r_s1_last),
        .i_coef      (coef),
        .o_fin       (fin)
    );

    prm_final u_final (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_mode  (r_mode),
        .i_fin   (fin),
        .i_stall (i_stall),
        .o_valid (o_valid),
        .o_pixel (o_pixel)
    );

    `PRM_ASSERT_NOW(a_stall_cause, i_clk, i_rst_n, o_stall,
        o_valid && i_stall && fin.valid)
    `PRM_ASSERT_NEXT(a_load_no_tap, i_clk, i_rst_n, accept && (i_mode == MODE_LOAD),
        !r_s1_valid)

endmodule

`default_nettype wire

>>> design/prm_ram.sv
`default_nettype none

module prm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

>>> design/prm_mac.sv
`default_nettype none
`include "polyphase_resample_mac_assert.svh"

module prm_mac (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_en,
    input  wire prm_pkg::t_mode                 i_mode,
    input  wire logic                           i_s1_valid,
    input  wire logic [prm_pkg::SAMPLE_W-1:0]   i_s1_sample,
    input  wire logic                           i_s1_last,
    input  wire logic [prm_pkg::COEF_W-1:0]     i_coef,
    output prm_pkg::t_fin                       o_fin
);

    import prm_pkg::*;

    logic                     r_s2_valid;
    logic                     r_s2_last;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic                     r_open;
    logic                     r_fin_valid;
    logic signed [ACC_W-1:0]  r_fin_acc;

    logic signed [SMP_W-1:0]  smp;
    logic signed [COEF_W-1:0] coef;
    logic signed [PROD_W-1:0] n_prod;
    logic signed [ACC_W-1:0]  base;
    logic signed [SUM_W-1:0]  sum;
    logic signed [ACC_W-1:0]  n_acc;

    // stage two: one multiply per tap
    always_comb begin
        smp    = $signed({1'b0, i_s1_sample}) - (i_mode.bias_on ? SMP_W'(BIAS) : SMP_W'(0));
        coef   = $signed(i_coef);
        n_prod = smp * coef;
    end

    // stage three: running sum with saturation, half lsb seed on a new pixel
    always_comb begin
        if (r_open) begin
            base = r_acc;
        end else if (i_mode.shift14) begin
            base = ACC_W'(1) << (SHIFT_HI - 1);
        end else begin
            base = ACC_W'(1) << (SHIFT_LO - 1);
        end
        sum = SUM_W'(base) + SUM_W'(r_prod);
        if (sum > SUM_W'(ACC_MAX)) begin
            n_acc = ACC_MAX;
        end else if (sum < SUM_W'(ACC_MIN)) begin
            n_acc = ACC_MIN;
        end else begin
            n_acc = sum[ACC_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid  <= 1'b0;
            r_open      <= 1'b0;
            r_fin_valid <= 1'b0;
        end else if (i_en) begin
            r_s2_valid  <= i_s1_valid;
            r_fin_valid <= r_s2_valid && r_s2_last;
            if (r_s2_valid) begin
                r_open <= !r_s2_last;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s2_last <= i_s1_last;
            r_prod    <= n_prod;
            if (r_s2_valid) begin
                r_acc     <= n_acc;
                r_fin_acc <= n_acc;
            end
        end
    end

    assign o_fin.valid = r_fin_valid;
    assign o_fin.acc   = r_fin_acc;

    `PRM_ASSERT_NEXT(a_last_closes, i_clk, i_rst_n, i_en && r_s2_valid && r_s2_last,
        !r_open && r_fin_valid)
    `PRM_ASSERT_NEXT(a_tap_opens, i_clk, i_rst_n, i_en && r_s2_valid && !r_s2_last,
        r_open && !r_fin_valid)

endmodule

`default_nettype wire

>>> design/prm_final.sv
`default_nettype none
`include "polyphase_resample_mac_assert.svh"

module prm_final (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_en,
    input  wire prm_pkg::t_mode                i_mode,
    input  wire prm_pkg::t_fin                 i_fin,
    input  wire logic                          i_stall,
    output logic                               o_valid,
    output logic [prm_pkg::PIXEL_W-1:0]        o_pixel
);

    import prm_pkg::*;

    logic signed [SUM_W-1:0] sum;
    logic signed [SUM_W-1:0] limit;
    logic [PIXEL_W-1:0]      n_pixel;

    // bias back in, clamp to the sample range, drop the fraction
    always_comb begin
        sum   = SUM_W'(i_fin.acc) + (i_mode.bias_on ? (SUM_W'(BIAS) << SHIFT_LO) : SUM_W'(0));
        limit = i_mode.shift14 ? (SUM_W'(i_mode.clamp_max) << SHIFT_HI)
                               : (SUM_W'(i_mode.clamp_max) << SHIFT_LO);
        if (sum < 0) begin
            n_pixel = '0;
        end else if (sum > limit) begin
            n_pixel = i_mode.clamp_max;
        end else if (i_mode.shift14) begin
            n_pixel = sum[SHIFT_HI+PIXEL_W-1:SHIFT_HI];
        end else begin
            n_pixel = sum[SHIFT_LO+PIXEL_W-1:SHIFT_LO];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en && i_fin.valid) begin
            o_valid <= 1'b1;
        end else if (!i_stall) begin
            o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en && i_fin.valid) begin
            o_pixel <= n_pixel;
        end
    end

    `PRM_ASSERT_NEXT(a_pixel_clamped, i_clk, i_rst_n, i_en && i_fin.valid,
        o_valid && (o_pixel <= $past(i_mode.clamp_max)))
    `PRM_ASSERT_NOW(a_fin_held, i_clk, i_rst_n, i_fin.valid && !i_en,
        o_valid && i_stall)

endmodule

`default_nettype wire
